// ===== rtl/core/circular_bitmap_block_allocator_macros.svh =====
// Assertion macros shared by the allocator checker.
`ifndef CIRCULAR_BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define CIRCULAR_BITMAP_BLOCK_ALLOCATOR_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define CBBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define CBBA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/cbba_pkg.sv =====
// Shared constants and types of the bitmap block allocator.
package cbba_pkg;

  localparam int unsigned NUM_BLOCKS = 32;
  localparam int unsigned IDX_W      = 5;   // bits of a block address
  localparam int unsigned TAG_W      = 4;
  localparam int unsigned LEN_W      = 6;
  localparam int unsigned MAX_OUT    = 32;  // claims per request at most

  // Mode codes of a request
  localparam logic MODE_MARK  = 1'b0;
  localparam logic MODE_ALLOC = 1'b1;

  // Access of the sequencer to the bitmap memory
  typedef struct packed {
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             wr_data;
  } cbba_mem_req_t;

endpackage

// ===== rtl/core/cbba_if.sv =====
// Request and response channel interfaces of the allocator.
interface cbba_req_if;
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic [cbba_pkg::TAG_W-1:0] file_id;
  logic [cbba_pkg::IDX_W-1:0] start_block;
  logic [cbba_pkg::LEN_W-1:0] length;

  modport source (output valid, mode, file_id, start_block, length, input ready);
  modport sink   (input valid, mode, file_id, start_block, length, output ready);
  modport monitor (input valid, ready, mode, file_id, start_block, length);
endinterface

interface cbba_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [cbba_pkg::TAG_W-1:0] file_tag;
  logic                      has_block;
  logic [cbba_pkg::IDX_W-1:0] block_index;
  logic                      last;
  logic                      success;

  modport source (output valid, file_tag, has_block, block_index, last, success,
                  input ready);
  modport sink   (input valid, file_tag, has_block, block_index, last, success,
                  output ready);
  modport monitor (input valid, ready, file_tag, has_block, block_index, last, success);
endinterface

// ===== rtl/core/cbba_bitmap_ram.sv =====
// Busy bitmap memory: one write and one registered read per cycle.
module cbba_bitmap_ram (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cbba_pkg::cbba_mem_req_t mem_req_i,
  output logic                    rd_data_o
);

  logic [cbba_pkg::NUM_BLOCKS-1:0] mem_q;
  logic [cbba_pkg::NUM_BLOCKS-1:0] vld_q;
  logic                            rd_mem_q;
  logic                            rd_vld_q;

  // Valid bits: an entry never written reads as free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (mem_req_i.wr_en) begin
      vld_q[mem_req_i.wr_addr] <= 1'b1;
    end
  end

  // Storage array and registered read port
  always_ff @(posedge clk_i) begin
    if (mem_req_i.wr_en) begin
      mem_q[mem_req_i.wr_addr] <= mem_req_i.wr_data;
    end
    rd_mem_q <= mem_q[mem_req_i.rd_addr];
    rd_vld_q <= vld_q[mem_req_i.rd_addr];
  end

  assign rd_data_o = rd_mem_q & rd_vld_q;

endmodule

// ===== rtl/core/cbba_scan_ctrl.sv =====
// Request sequencer: marks blocks and walks the bitmap for allocations.
module cbba_scan_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  cbba_req_if.sink                req_i,
  cbba_rsp_if.source              rsp_o,
  output cbba_pkg::cbba_mem_req_t mem_req_o,
  input  logic                    rd_data_i
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]                 state_q, state_d;
  logic                       first_q, first_d;
  logic [cbba_pkg::TAG_W-1:0] tag_q, tag_d;
  logic [cbba_pkg::IDX_W-1:0] start_q, start_d;
  logic [cbba_pkg::LEN_W-1:0] want_q, want_d;
  logic [cbba_pkg::IDX_W-1:0] pos_q, pos_d;
  logic [cbba_pkg::LEN_W-1:0] cnt_q, cnt_d;
  logic [cbba_pkg::IDX_W-1:0] pend_q, pend_d;

  logic                       ov_q, ov_d;
  logic [cbba_pkg::TAG_W-1:0] o_tag_q, o_tag_d;
  logic                       o_has_q, o_has_d;
  logic [cbba_pkg::IDX_W-1:0] o_idx_q, o_idx_d;
  logic                       o_last_q, o_last_d;
  logic                       o_ok_q, o_ok_d;

  logic                       slot_free;
  logic                       req_beat;
  logic                       emit;
  logic                       start_oob;
  logic                       in_oob;
  logic [cbba_pkg::IDX_W-1:0] pos_nxt;
  logic [cbba_pkg::LEN_W-1:0] cnt_new;
  logic                       stop;

  assign slot_free = !ov_q || rsp_o.ready;
  assign req_i.ready = (state_q == ST_IDLE);
  assign req_beat  = req_i.valid && req_i.ready;
  assign start_oob = (32'(start_q) >= cbba_pkg::NUM_BLOCKS);
  assign in_oob    = (32'(req_i.start_block) >= cbba_pkg::NUM_BLOCKS);
  assign pos_nxt   = (32'(pos_q) == cbba_pkg::NUM_BLOCKS - 1) ? '0 : pos_q + 1'b1;
  assign cnt_new   = rd_data_i ? cnt_q : cnt_q + 1'b1;
  assign stop      = (cnt_new >= want_q) || (cnt_new >= cbba_pkg::LEN_W'(cbba_pkg::MAX_OUT))
                     || (pos_nxt == start_q);

  // Sequencer
  always_comb begin
    state_d  = state_q;
    first_d  = first_q;
    tag_d    = tag_q;
    start_d  = start_q;
    want_d   = want_q;
    pos_d    = pos_q;
    cnt_d    = cnt_q;
    pend_d   = pend_q;
    emit     = 1'b0;
    o_tag_d  = o_tag_q;
    o_has_d  = o_has_q;
    o_idx_d  = o_idx_q;
    o_last_d = o_last_q;
    o_ok_d   = o_ok_q;
    mem_req_o.rd_addr = pos_q;
    mem_req_o.wr_en   = 1'b0;
    mem_req_o.wr_addr = pos_q;
    mem_req_o.wr_data = 1'b1;

    case (state_q)
      ST_IDLE: begin
        mem_req_o.rd_addr = req_i.start_block;
        if (req_beat) begin
          tag_d   = req_i.file_id;
          start_d = req_i.start_block;
          want_d  = req_i.length;
          pos_d   = req_i.start_block;
          cnt_d   = '0;
          first_d = 1'b1;
          if (req_i.mode == cbba_pkg::MODE_MARK) begin
            mem_req_o.wr_en   = !in_oob;
            mem_req_o.wr_addr = req_i.start_block;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // data of pos_q is on rd_data_i; re-read it while the output stalls
        if (slot_free) begin
          if (first_q && (start_oob || rd_data_i)) begin
            emit     = 1'b1;
            o_tag_d  = tag_q;
            o_has_d  = 1'b0;
            o_idx_d  = '0;
            o_last_d = 1'b1;
            o_ok_d   = 1'b0;
            state_d  = ST_IDLE;
          end else if (first_q && (want_q == '0)) begin
            emit     = 1'b1;
            o_tag_d  = tag_q;
            o_has_d  = 1'b0;
            o_idx_d  = '0;
            o_last_d = 1'b1;
            o_ok_d   = 1'b1;
            state_d  = ST_IDLE;
          end else begin
            first_d = 1'b0;
            if (!rd_data_i) begin
              // claim; the previous claim is now known not to be the last
              mem_req_o.wr_en = 1'b1;
              pend_d = pos_q;
              cnt_d  = cnt_new;
              if (cnt_q != '0) begin
                emit     = 1'b1;
                o_tag_d  = tag_q;
                o_has_d  = 1'b1;
                o_idx_d  = pend_q;
                o_last_d = 1'b0;
                o_ok_d   = 1'b0;
              end
            end
            pos_d = pos_nxt;
            mem_req_o.rd_addr = pos_nxt;
            if (stop) begin
              state_d = ST_FINISH;
            end
          end
        end
      end

      ST_FINISH: begin
        // send the held claim as the final beat
        if (slot_free) begin
          emit     = 1'b1;
          o_tag_d  = tag_q;
          o_has_d  = 1'b1;
          o_idx_d  = pend_q;
          o_last_d = 1'b1;
          o_ok_d   = (cnt_q == want_q);
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    if (emit) begin
      ov_d = 1'b1;
    end else if (rsp_o.ready) begin
      ov_d = 1'b0;
    end else begin
      ov_d = ov_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      first_q <= 1'b0;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      first_q <= first_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q    <= tag_d;
    start_q  <= start_d;
    want_q   <= want_d;
    pos_q    <= pos_d;
    pend_q   <= pend_d;
    o_tag_q  <= o_tag_d;
    o_has_q  <= o_has_d;
    o_idx_q  <= o_idx_d;
    o_last_q <= o_last_d;
    o_ok_q   <= o_ok_d;
  end

  assign rsp_o.valid       = ov_q;
  assign rsp_o.file_tag    = o_tag_q;
  assign rsp_o.has_block   = o_has_q;
  assign rsp_o.block_index = o_idx_q;
  assign rsp_o.last        = o_last_q;
  assign rsp_o.success     = o_ok_q;

endmodule

// ===== rtl/core/circular_bitmap_block_allocator.sv =====
// Top level of the next-fit bitmap block allocator.
// Usage:
//   req_i carries one request per beat: mode 0 marks start_block busy and
//   gives no response; mode 1 allocates up to length blocks for file_id,
//   walking forward from start_block and wrapping at the last block.
//   rsp_o gives one beat per claimed block, the final one with last set and
//   success telling whether all blocks were found; a busy start block gives
//   a single failure beat, a zero length on a free start a single success beat.
// Timing:
//   A mark is written as it is accepted; the next request can be taken in the following cycle.
//   An allocate walks one block per cycle, while its output is not stalled,
//   through the bitmap memory (one read and one write port, read data
//   registered), and the next request is taken once the walk is done.
//   A failure or zero-length beat is set in the output register from the first
//   scan step; a claim beat is held until the next claim or the end of the
//   walk is seen, and only then goes to the output register.
// Reset: all blocks are free after reset; no clearing pass is needed.
// Stall: responses sit in one output register; while it is full and not
//   taken, the walk holds and reissues its current read.
module circular_bitmap_block_allocator (
  input  logic       clk_i,
  input  logic       rst_ni,
  cbba_req_if.sink   req_i,
  cbba_rsp_if.source rsp_o
);

  cbba_pkg::cbba_mem_req_t mem_req;
  logic                    rd_data;

  cbba_scan_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .rsp_o     (rsp_o),
    .mem_req_o (mem_req),
    .rd_data_i (rd_data)
  );

  cbba_bitmap_ram u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .mem_req_i (mem_req),
    .rd_data_o (rd_data)
  );

endmodule

// ===== rtl/core/cbba_checker.sv =====
// Port-level checks of the allocator and their binding to the top level.
`include "circular_bitmap_block_allocator_macros.svh"

module cbba_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       req_valid_i,
  input logic                       req_ready_i,
  input logic                       req_mode_i,
  input logic                       rsp_valid_i,
  input logic                       rsp_ready_i,
  input logic [cbba_pkg::TAG_W-1:0] rsp_file_tag_i,
  input logic                       rsp_has_block_i,
  input logic [cbba_pkg::IDX_W-1:0] rsp_block_index_i,
  input logic                       rsp_last_i,
  input logic                       rsp_success_i
);

  logic                                   rsp_stall;
  logic                                   alloc_beat;
  logic                                   mark_beat;
  logic [cbba_pkg::TAG_W+cbba_pkg::IDX_W+2:0] rsp_view;

  // Handshake views
  assign rsp_stall  = rsp_valid_i && !rsp_ready_i;
  assign alloc_beat = req_valid_i && req_ready_i && (req_mode_i == cbba_pkg::MODE_ALLOC);
  assign mark_beat  = req_valid_i && req_ready_i && (req_mode_i == cbba_pkg::MODE_MARK);
  assign rsp_view   = {rsp_file_tag_i, rsp_has_block_i, rsp_block_index_i, rsp_last_i,
                       rsp_success_i};

  `CBBA_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_stall, rsp_valid_i && $stable(rsp_view))
  `CBBA_ASSERT_NEXT(a_alloc_busy, clk_i, rst_ni, alloc_beat, !req_ready_i)
  `CBBA_ASSERT_NEXT(a_mark_quick, clk_i, rst_ni, mark_beat, req_ready_i)
  `CBBA_ASSERT_SAME(a_noblock_last, clk_i, rst_ni, rsp_valid_i && !rsp_has_block_i, rsp_last_i)
  `CBBA_ASSERT_SAME(a_ok_on_last, clk_i, rst_ni, rsp_valid_i && !rsp_last_i, !rsp_success_i)

endmodule

bind circular_bitmap_block_allocator cbba_checker u_cbba_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req_i.valid),
  .req_ready_i       (req_i.ready),
  .req_mode_i        (req_i.mode),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .rsp_file_tag_i    (rsp_o.file_tag),
  .rsp_has_block_i   (rsp_o.has_block),
  .rsp_block_index_i (rsp_o.block_index),
  .rsp_last_i        (rsp_o.last),
  .rsp_success_i     (rsp_o.success)
);

// ===== tb/sv/circular_bitmap_block_allocator_checker.sv =====
// Checker for the bitmap block allocator: predicts grants from accepted requests and compares.
`timescale 1ns / 100ps

module circular_bitmap_block_allocator_checker
  import cbba_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  cbba_req_if.monitor        req_i,
  cbba_rsp_if.monitor        rsp_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 beat_count_o,
  output int                 claim_count_o
);

  // One expected response beat
  typedef struct packed {
    logic [TAG_W-1:0] file_tag;
    logic             has_block;
    logic [IDX_W-1:0] block_index;
    logic             last;
    logic             success;
  } grant_t;

  logic [NUM_BLOCKS-1:0] busy_map;   // shadow of the block bitmap
  grant_t                grant_q[$]; // grants still to come, oldest first
  grant_t                due;

  // Apply one request to the shadow bitmap and queue the grants it yields
  function automatic void predict_request(input logic             mode,
                                          input logic [TAG_W-1:0] tag,
                                          input logic [IDX_W-1:0] start,
                                          input logic [LEN_W-1:0] want);
    grant_t      g;
    grant_t      run[$];
    int unsigned pos;
    int unsigned steps;
    int          n;
    g = '{file_tag: tag, has_block: 1'b0, block_index: '0, last: 1'b1, success: 1'b0};
    if (mode == MODE_MARK) begin
      if (int'(start) < NUM_BLOCKS) busy_map[start] = 1'b1;
      return;
    end
    // busy or out-of-range start: single failure beat
    if (int'(start) >= NUM_BLOCKS || busy_map[start]) begin
      grant_q.push_back(g);
      return;
    end
    // zero length: single success beat, nothing claimed
    if (want == '0) begin
      g.success = 1'b1;
      grant_q.push_back(g);
      return;
    end
    // next-fit walk, wrapping, until enough blocks or back at the start
    pos = 32'(start);
    for (steps = 0; steps < NUM_BLOCKS; steps++) begin
      if (!busy_map[pos[IDX_W-1:0]]) begin
        busy_map[pos[IDX_W-1:0]] = 1'b1;
        g.has_block   = 1'b1;
        g.block_index = pos[IDX_W-1:0];
        g.last        = 1'b0;
        g.success     = 1'b0;
        run.push_back(g);
      end
      pos = (pos + 1 >= NUM_BLOCKS) ? 0 : pos + 1;
      if (run.size() >= int'(want) || run.size() >= MAX_OUT || pos == 32'(start)) break;
    end
    n = run.size();
    run[n-1].last    = 1'b1;
    run[n-1].success = (n == int'(want));
    foreach (run[i]) grant_q.push_back(run[i]);
  endfunction

  // Watch both channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_map      = '0;
      grant_q.delete();
      fail_count_o  = 0;
      pending_o     = 0;
      beat_count_o  = 0;
      claim_count_o = 0;
    end else begin
      if (req_i.valid && req_i.ready)
        predict_request(req_i.mode, req_i.file_id, req_i.start_block, req_i.length);
      if (rsp_i.valid && rsp_i.ready) begin
        beat_count_o++;
        if (rsp_i.has_block === 1'b1) claim_count_o++;
        if (grant_q.size() == 0) begin
          $error("response beat with no grant pending: file_tag %0d block_index %0d",
                 rsp_i.file_tag, rsp_i.block_index);
          fail_count_o++;
        end else begin
          due = grant_q.pop_front();
          if (rsp_i.file_tag !== due.file_tag) begin
            $error("file_tag: expected %0d, got %0d", due.file_tag, rsp_i.file_tag);
            fail_count_o++;
          end
          if (rsp_i.has_block !== due.has_block) begin
            $error("has_block: expected %0d, got %0d", due.has_block, rsp_i.has_block);
            fail_count_o++;
          end
          if (rsp_i.block_index !== due.block_index) begin
            $error("block_index: expected %0d, got %0d", due.block_index, rsp_i.block_index);
            fail_count_o++;
          end
          if (rsp_i.last !== due.last) begin
            $error("last: expected %0d, got %0d", due.last, rsp_i.last);
            fail_count_o++;
          end
          if (rsp_i.success !== due.success) begin
            $error("success: expected %0d, got %0d", due.success, rsp_i.success);
            fail_count_o++;
          end
        end
      end
      pending_o = grant_q.size();
    end
  end

endmodule

// ===== tb/sv/circular_bitmap_block_allocator_tb.sv =====
// Top of the allocator testbench: clock, reset, request and response drivers, verdict.
`timescale 1ns / 100ps

module circular_bitmap_block_allocator_tb;
  import cbba_pkg::*;

  localparam int RANDOM_ITEMS = 470;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 48;   // a full walk plus margin
  localparam int HOLD_CYCLES  = 300;

  // Receiver stall styles
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_COMB} rx_style_e;

  logic clk_i;
  logic rst_ni;

  cbba_req_if req_if();
  cbba_rsp_if rsp_if();

  int fail_count;
  int pending;
  int beat_count;
  int claim_count;

  int cycle_count  = 0;
  int reqs_taken   = 0;
  int allocs_taken = 0;
  int marks_taken  = 0;
  int burst_left   = 0;
  bit gaps_on      = 1'b1;
  int holds_done   = 0;

  circular_bitmap_block_allocator dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  circular_bitmap_block_allocator_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .beat_count_o (beat_count),
    .claim_count_o(claim_count)
  );

  // Clock, 10 ns period
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("circular_bitmap_block_allocator_tb: errors");
      $finish;
    end
  end

  // Offer one request beat; gaps fall between bursts of random length
  task automatic offer(input logic             mode,
                       input logic [TAG_W-1:0] tag,
                       input logic [IDX_W-1:0] start,
                       input logic [LEN_W-1:0] len);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        @(negedge clk_i);
        req_if.valid = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    @(negedge clk_i);
    req_if.valid       = 1'b1;
    req_if.mode        = mode;
    req_if.file_id     = tag;
    req_if.start_block = start;
    req_if.length      = len;
    do @(posedge clk_i); while (!req_if.ready);
    burst_left--;
    reqs_taken++;
    if (mode == MODE_ALLOC) allocs_taken++;
    else marks_taken++;
  endtask

  // Response side: own stall pattern, plus two long hold-offs
  initial begin : receiver
    int        hold_left;
    int        phase_left;
    int        hold_at[2];
    rx_style_e style;
    hold_left  = 0;
    phase_left = 0;
    hold_at    = '{9, 260};
    style      = RX_OPEN;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        rsp_if.ready = 1'b0;
        hold_left--;
      end else if (holds_done < 2 && reqs_taken >= hold_at[holds_done]) begin
        holds_done++;
        hold_left    = HOLD_CYCLES - 1;
        rsp_if.ready = 1'b0;
      end else begin
        if (phase_left == 0) begin
          style      = rx_style_e'($urandom_range(0, 3));
          phase_left = $urandom_range(10, 60);
        end
        phase_left--;
        case (style)
          RX_OPEN:   rsp_if.ready = 1'b1;
          RX_COIN:   rsp_if.ready = 1'($urandom_range(0, 1));
          RX_SPARSE: rsp_if.ready = ($urandom_range(0, 3) == 0);
          default:   rsp_if.ready = (cycle_count % 4 != 3);
        endcase
      end
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    logic             mode;
    logic [TAG_W-1:0] tag;
    logic [IDX_W-1:0] start;
    logic [LEN_W-1:0] len;
    req_if.valid       = 1'b0;
    req_if.mode        = MODE_MARK;
    req_if.file_id     = '0;
    req_if.start_block = '0;
    req_if.length      = '0;
    rst_ni = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: fresh bitmap, then filling it through every case
    offer(MODE_ALLOC, 4'd0,  5'd5,  6'd0);   // zero length on a free start
    offer(MODE_ALLOC, 4'd15, 5'd31, 6'd1);   // top block
    offer(MODE_ALLOC, 4'd1,  5'd31, 6'd4);   // busy start
    offer(MODE_MARK,  4'd0,  5'd0,  6'd63);  // mark, length ignored
    offer(MODE_MARK,  4'd0,  5'd31, 6'd0);   // mark an already busy block
    offer(MODE_MARK,  4'd3,  5'd10, 6'd5);
    offer(MODE_ALLOC, 4'd2,  5'd0,  6'd2);   // busy start at block 0
    offer(MODE_ALLOC, 4'd3,  5'd1,  6'd3);
    offer(MODE_ALLOC, 4'd4,  5'd8,  6'd4);   // skips the marked block
    offer(MODE_MARK,  4'd0,  5'd20, 6'd0);
    offer(MODE_MARK,  4'd0,  5'd22, 6'd0);
    offer(MODE_ALLOC, 4'd5,  5'd19, 6'd5);   // skips two marks
    offer(MODE_ALLOC, 4'd6,  5'd28, 6'd6);   // wraps past the top
    offer(MODE_ALLOC, 4'd7,  5'd7,  6'd63);  // takes the rest, ring exhausted
    offer(MODE_ALLOC, 4'd8,  5'd14, 6'd1);   // full bitmap
    offer(MODE_MARK,  4'd0,  5'd0,  6'd0);
    offer(MODE_ALLOC, 4'd9,  5'd0,  6'd0);   // zero length on a busy start

    // random
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      gaps_on = !(i >= 150 && i < 220);
      mode  = ($urandom_range(0, 3) != 0) ? MODE_ALLOC : MODE_MARK;
      tag   = TAG_W'($urandom_range(0, 15));
      start = IDX_W'($urandom_range(0, 31));
      case ($urandom_range(0, 9))
        0:       len = '0;
        1:       len = LEN_W'($urandom_range(33, 63));
        2, 3:    len = LEN_W'($urandom);
        default: len = LEN_W'($urandom_range(1, 8));
      endcase
      offer(mode, tag, start, len);
    end
    @(negedge clk_i);
    req_if.valid = 1'b0;

    // drain, then let a full walk's worth of cycles pass
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("run covered %0d requests (%0d allocate, %0d mark), %0d response beats",
             reqs_taken, allocs_taken, marks_taken, beat_count);
    $display("%0d blocks claimed, %0d long receiver hold-offs, %0d mismatches",
             claim_count, holds_done, fail_count);
    if (fail_count == 0)
      $display("circular_bitmap_block_allocator_tb: clean");
    else
      $display("circular_bitmap_block_allocator_tb: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/cbba_pkg.sv
rtl/core/cbba_if.sv
rtl/core/cbba_bitmap_ram.sv
rtl/core/cbba_scan_ctrl.sv
rtl/core/circular_bitmap_block_allocator.sv
rtl/core/cbba_checker.sv
tb/sv/circular_bitmap_block_allocator_checker.sv
tb/sv/circular_bitmap_block_allocator_tb.sv
